// ===== hw/rtl/rlpf_pkg.sv =====
// ----------------------------------------------------------------------------
// rlpf_pkg
// Shared types, codes and helper functions for the random LED pattern fader.
// ----------------------------------------------------------------------------
package rlpf_pkg;

  localparam int RGB_W     = 24;
  localparam int PAL_SLOTS = 6;
  localparam int MASK_W    = 6;
  localparam int GEN_W     = 16;

  // item modes, carried in tuser
  localparam logic [1:0] MODE_FADE = 2'd0;
  localparam logic [1:0] MODE_SET  = 2'd1;
  localparam logic [1:0] MODE_ADV  = 2'd2;

  // configuration register indexes
  localparam logic [2:0] REG_MIN_LIT   = 3'd0;
  localparam logic [2:0] REG_PAL_COUNT = 3'd1;
  localparam logic [2:0] REG_PAL_0     = 3'd2;
  localparam logic [2:0] REG_PAL_1     = 3'd3;
  localparam logic [2:0] REG_PAL_2     = 3'd4;
  localparam logic [2:0] REG_PAL_3     = 3'd5;
  localparam logic [2:0] REG_PAL_4     = 3'd6;
  localparam logic [2:0] REG_PAL_5     = 3'd7;

  localparam logic [2:0]       MAX_COUNT    = 3'd6;
  localparam logic [GEN_W-1:0] GEN_SEED     = 16'h00BF;
  localparam logic [GEN_W-1:0] GEN_ALL_ON   = 16'h003F;
  localparam logic [GEN_W-1:0] SEARCH_LAST  = 16'd65534;

  // request from the sequencer to the pattern search unit
  typedef struct packed {
    logic       start;
    logic [2:0] need;
  } srch_req_t;

  function automatic logic [GEN_W-1:0] xs_next(input logic [GEN_W-1:0] s);
    logic [GEN_W-1:0] a;
    logic [GEN_W-1:0] b;
    a = s ^ (s >> 7);
    b = a ^ (a << 9);
    return b ^ (b >> 13);
  endfunction

  function automatic logic [2:0] ones6(input logic [MASK_W-1:0] v);
    logic [2:0] n;
    n = '0;
    for (int i = 0; i < MASK_W; i++) begin
      n = n + 3'(v[i]);
    end
    return n;
  endfunction

  function automatic logic [7:0] step_byte(input logic [7:0] c, input logic [7:0] t);
    logic [7:0] r;
    r = c;
    if (c > t) r = c - 8'd1;
    else if (c < t) r = c + 8'd1;
    return r;
  endfunction

  function automatic logic [RGB_W-1:0] fade_color(input logic [RGB_W-1:0] c,
                                                  input logic [RGB_W-1:0] t);
    return {step_byte(c[23:16], t[23:16]),
            step_byte(c[15:8],  t[15:8]),
            step_byte(c[7:0],   t[7:0])};
  endfunction

endpackage

// ===== hw/rtl/rlpf_search.sv =====
// ----------------------------------------------------------------------------
// rlpf_search
// Xorshift16 generator and the search for the next acceptable lit pattern,
// one generator step per cycle.
// ----------------------------------------------------------------------------
module rlpf_search import rlpf_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  srch_req_t         req,
  output logic              done,
  output logic [MASK_W-1:0] lit_mask
);

  logic [GEN_W-1:0]  gen_r,   gen_nxt;
  logic [MASK_W-1:0] prev_r,  prev_nxt;
  logic [GEN_W-1:0]  tries_r, tries_nxt;
  logic [2:0]        need_r,  need_nxt;
  logic              busy_r,  busy_nxt;
  logic              done_r,  done_nxt;
  logic [GEN_W-1:0]  step;
  logic              hit;

  assign step = xs_next(gen_r);
  assign hit  = (ones6(step[MASK_W-1:0]) >= need_r) && (step[MASK_W-1:0] != prev_r);

  always_comb begin
    gen_nxt   = gen_r;
    prev_nxt  = prev_r;
    tries_nxt = tries_r;
    need_nxt  = need_r;
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    if (req.start) begin
      need_nxt  = req.need;
      tries_nxt = '0;
      if (req.need >= MAX_COUNT) begin
        gen_nxt  = GEN_ALL_ON;
        prev_nxt = GEN_ALL_ON[MASK_W-1:0];
        done_nxt = 1'b1;
      end else if (req.need == 3'd0) begin
        prev_nxt = gen_r[MASK_W-1:0];
        done_nxt = 1'b1;
      end else begin
        busy_nxt = 1'b1;
      end
    end else if (busy_r) begin
      gen_nxt   = step;
      tries_nxt = tries_r + 16'd1;
      // give up after the last allowed step and keep that state
      if (hit || tries_r == SEARCH_LAST) begin
        busy_nxt = 1'b0;
        prev_nxt = step[MASK_W-1:0];
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gen_r  <= GEN_SEED;
      prev_r <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      gen_r  <= gen_nxt;
      prev_r <= prev_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tries_r <= tries_nxt;
    need_r  <= need_nxt;
  end

  assign done     = done_r;
  assign lit_mask = gen_r[MASK_W-1:0];

endmodule

// ===== hw/rtl/random_led_pattern_fader.sv =====
// ----------------------------------------------------------------------------
// random_led_pattern_fader
// Colour fader for up to six RGB LEDs with a randomly chosen lit pattern.
// ----------------------------------------------------------------------------
// Usage:
//   in_* carries one command item: tuser is the mode (fade tick, set target,
//   advance pattern), tdata the LED index and the random sample. out_* gives
//   the result items, tlast on the last result of each command.
//   cfg_* writes min_lit, palette_count and the six palette colours; write
//   only while the block is idle.
// Timing:
//   one item at a time. A fade tick reads each LED's current and target
//   colour from the colour memory, one LED per cycle while the output
//   accepts, and emits NUM_LEDS items back to back. Set target reads the
//   entry, then modifies and writes it. Advance pattern runs the xorshift
//   search, one generator step per cycle (up to 65535 steps), then copies
//   targets to current colours, one LED after another.
// Reset clears all colours to black (per-entry valid bits, no clearing pass)
// and loads the generator seed and the register defaults. A stalled receiver
// holds the sequencer; a new command is taken as soon as the sequencer is
// idle, even while the last result still waits in the output register.
// ----------------------------------------------------------------------------
module random_led_pattern_fader import rlpf_pkg::*; #(
  parameter int NUM_LEDS = 6
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // led_index[2:0], random_sample[5:3]
  input  logic [1:0]  in_tuser,   // mode[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // led_number[2:0], color[26:3], accepted[27],
                                  // lit_mask[33:28]
  output logic        out_tlast,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [23:0] cfg_wdata
);

  localparam int AW = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
  localparam logic [AW-1:0] LAST_LED = AW'(NUM_LEDS - 1);
  localparam int EW = 2 * RGB_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_FADE = 3'd1;
  localparam logic [2:0] S_SET  = 3'd2;
  localparam logic [2:0] S_SRCH = 3'd3;
  localparam logic [2:0] S_COPY = 3'd4;
  localparam logic [2:0] S_POST = 3'd5;

  // configuration registers
  logic [2:0]       min_lit_r;
  logic [2:0]       pal_cnt_r;
  logic [RGB_W-1:0] pal_r [PAL_SLOTS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_lit_r <= 3'd5;
      pal_cnt_r <= 3'd3;
      pal_r[0]  <= 24'hFFFFFF;
      pal_r[1]  <= 24'h666666;
      pal_r[2]  <= 24'h66FFFF;
      pal_r[3]  <= '0;
      pal_r[4]  <= '0;
      pal_r[5]  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_MIN_LIT:   min_lit_r <= cfg_wdata[2:0];
        REG_PAL_COUNT: pal_cnt_r <= cfg_wdata[2:0];
        REG_PAL_0:     pal_r[0]  <= cfg_wdata;
        REG_PAL_1:     pal_r[1]  <= cfg_wdata;
        REG_PAL_2:     pal_r[2]  <= cfg_wdata;
        REG_PAL_3:     pal_r[3]  <= cfg_wdata;
        REG_PAL_4:     pal_r[4]  <= cfg_wdata;
        REG_PAL_5:     pal_r[5]  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // colour memory: each entry holds {current, target}
  logic [EW-1:0]       mem [NUM_LEDS];
  logic [NUM_LEDS-1:0] vld_r;
  logic [EW-1:0]       q_r;
  logic                qv_r;
  logic                mem_re, mem_we;
  logic [AW-1:0]       mem_ra, mem_wa;
  logic [EW-1:0]       mem_wd;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      q_r <= mem[mem_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      qv_r  <= 1'b0;
    end else begin
      if (mem_we) vld_r[mem_wa] <= 1'b1;
      if (mem_re) qv_r <= vld_r[mem_ra];
    end
  end

  // an entry never written reads as black
  logic [RGB_W-1:0] ent_cur, ent_tgt;
  assign ent_cur = qv_r ? q_r[EW-1:RGB_W] : '0;
  assign ent_tgt = qv_r ? q_r[RGB_W-1:0]  : '0;

  // pattern search unit
  srch_req_t         req;
  logic              srch_done;
  logic [MASK_W-1:0] lit_mask;

  rlpf_search u_search (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (req),
    .done     (srch_done),
    .lit_mask (lit_mask)
  );

  // sequencer
  logic [2:0]    state_r, state_nxt;
  logic [AW-1:0] cnt_r,   cnt_nxt;
  logic          set_ok_r,  set_ok_nxt;
  logic [2:0]    set_idx_r, set_idx_nxt;
  logic [2:0]    set_smp_r, set_smp_nxt;

  logic              out_valid_r;
  logic [39:0]       out_data_r;
  logic              out_last_r;
  logic              out_free;
  logic              emit;
  logic [2:0]        emit_led;
  logic [RGB_W-1:0]  emit_color;
  logic              emit_acc;
  logic              emit_last;

  logic [RGB_W-1:0]  fade_c;
  logic [2:0]        count;
  logic [2:0]        smp_m1;
  logic [RGB_W-1:0]  pal_sel;
  logic              led_lit;
  logic              idx_ok;

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == S_IDLE);
  assign fade_c    = fade_color(ent_cur, ent_tgt);
  assign count     = (pal_cnt_r > MAX_COUNT) ? MAX_COUNT : pal_cnt_r;
  assign smp_m1    = set_smp_r - 3'd1;
  assign pal_sel   = (smp_m1 < 3'(PAL_SLOTS)) ? pal_r[smp_m1] : '0;
  assign led_lit   = lit_mask[set_idx_r[AW-1:0]];
  assign idx_ok    = in_tdata[2:0] < 3'(NUM_LEDS);

  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    set_ok_nxt  = set_ok_r;
    set_idx_nxt = set_idx_r;
    set_smp_nxt = set_smp_r;
    mem_re      = 1'b0;
    mem_ra      = cnt_r;
    mem_we      = 1'b0;
    mem_wa      = cnt_r;
    mem_wd      = '0;
    emit        = 1'b0;
    emit_led    = '0;
    emit_color  = '0;
    emit_acc    = 1'b0;
    emit_last   = 1'b1;
    req         = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          case (in_tuser)
            MODE_FADE: begin
              mem_re    = 1'b1;
              mem_ra    = '0;
              cnt_nxt   = '0;
              state_nxt = S_FADE;
            end
            MODE_SET: begin
              set_ok_nxt  = idx_ok;
              set_idx_nxt = in_tdata[2:0];
              set_smp_nxt = in_tdata[5:3];
              mem_re      = idx_ok;
              mem_ra      = in_tdata[AW-1:0];
              state_nxt   = S_SET;
            end
            MODE_ADV: begin
              req.start = 1'b1;
              req.need  = (min_lit_r > MAX_COUNT) ? MAX_COUNT : min_lit_r;
              state_nxt = S_SRCH;
            end
            default: ;  // unused mode, dropped
          endcase
        end
      end
      S_FADE: begin
        if (out_free) begin
          mem_we     = 1'b1;
          mem_wd     = {fade_c, ent_tgt};
          emit       = 1'b1;
          emit_led   = 3'(cnt_r);
          emit_color = fade_c;
          emit_last  = (cnt_r == LAST_LED);
          if (cnt_r == LAST_LED) begin
            state_nxt = S_IDLE;
          end else begin
            // next entry read overlaps this write, always a different address
            mem_re  = 1'b1;
            mem_ra  = cnt_r + AW'(1);
            cnt_nxt = cnt_r + AW'(1);
          end
        end
      end
      S_SET: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_led  = set_idx_r;
          state_nxt = S_IDLE;
          if (set_ok_r) begin
            mem_we     = 1'b1;
            mem_wa     = set_idx_r[AW-1:0];
            emit_color = ent_tgt;
            if (!led_lit) begin
              emit_color = '0;
              emit_acc   = 1'b1;
            end else if (set_smp_r != 3'd0 && set_smp_r <= count) begin
              emit_color = pal_sel;
              emit_acc   = 1'b1;
            end
            mem_wd = {ent_cur, emit_color};
          end
        end
      end
      S_SRCH: begin
        if (srch_done) begin
          mem_re    = 1'b1;
          mem_ra    = '0;
          cnt_nxt   = '0;
          state_nxt = S_COPY;
        end
      end
      S_COPY: begin
        mem_we = 1'b1;
        mem_wd = {ent_tgt, ent_tgt};
        if (cnt_r == LAST_LED) begin
          state_nxt = S_POST;
        end else begin
          mem_re  = 1'b1;
          mem_ra  = cnt_r + AW'(1);
          cnt_nxt = cnt_r + AW'(1);
        end
      end
      S_POST: begin
        if (out_free) begin
          emit      = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (emit) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    set_ok_r  <= set_ok_nxt;
    set_idx_r <= set_idx_nxt;
    set_smp_r <= set_smp_nxt;
    if (emit) begin
      out_data_r <= {6'd0, lit_mask, emit_acc, emit_color, emit_led};
      out_last_r <= emit_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

`ifndef NO_ASSERTIONS
  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we && mem_re |-> mem_wa != mem_ra)
    else $error("colour memory read and write hit the same entry");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= LAST_LED)
    else $error("LED counter beyond last LED");

  a_no_emit_over_full: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> out_free)
    else $error("result written over an item not yet taken");

  a_adv_starts_search: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser == MODE_ADV |=> state_r == S_SRCH)
    else $error("advance item did not start the search");
`endif

endmodule
